// ===== rtl/core/sus_pkg.sv =====
`default_nettype none

package sus_pkg;

  // Fraction bits of every log2 value and of every probability.
  localparam int unsigned LOG_FRAC  = 24;
  localparam int unsigned PROB_BITS = 24;
  // The four cells of the 2x2 table plus the four marginal counts.
  localparam int unsigned NUM_CELLS = 8;

  // Fraction of log2(1 + k/2^ltb), truncated, by repeated squaring in Q2.30.
  // Only evaluated at elaboration to fill constant tables.
  function automatic logic [LOG_FRAC-1:0] log_frac(input int unsigned k,
                                                   input int unsigned ltb);
    logic [63:0]         y;
    logic [LOG_FRAC-1:0] acc;
    y   = (64'(64'd1 << ltb) + 64'(k)) << (30 - ltb);
    acc = '0;
    for (int unsigned i = 1; i <= LOG_FRAC; i++) begin
      y = (y * y) >> 30;
      if (y >= (64'd2 << 30)) begin
        y = y >> 1;
        acc[LOG_FRAC-i] = 1'b1;
      end
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sus_log2.sv =====
`default_nettype none

module sus_log2 import sus_pkg::*; #(
  parameter int unsigned CW  = 32,
  parameter int unsigned LTB = 10,
  parameter int unsigned EW  = 5
) (
  input  wire logic                   clk_i,
  input  wire logic                   en_i,
  input  wire logic [CW-1:0]          x_i,
  output logic      [EW+LOG_FRAC-1:0] log_o
);

  localparam int unsigned TSIZE = 1 << LTB;
  localparam int unsigned XW    = CW + LTB;

  typedef logic [LOG_FRAC-1:0] ltab_t [TSIZE];

  function automatic ltab_t build_tab();
    ltab_t t;
    for (int unsigned k = 0; k < TSIZE; k++) begin
      t[k] = log_frac(k, LTB);
    end
    return t;
  endfunction

  localparam ltab_t LTAB = build_tab();

  logic [EW-1:0] e_d, e_q;
  logic [CW-1:0] x_q;
  logic [XW-1:0] norm;
  logic [LTB-1:0] idx;
  logic [EW+LOG_FRAC-1:0] log_d, log_q;

  // Leading-one position; zero input reads as position zero.
  always_comb begin
    e_d = '0;
    for (int unsigned i = 0; i < CW; i++) begin
      if (x_i[i]) e_d = EW'(i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_i;
      e_q <= e_d;
    end
  end

  // Bring the leading one to the top, then take the bits just below it.
  assign norm  = {x_q, {LTB{1'b0}}} << (EW'(CW - 1) - e_q);
  assign idx   = norm[XW-2 -: LTB];
  assign log_d = {e_q, LTAB[idx]};

  always_ff @(posedge clk_i) begin
    if (en_i) log_q <= log_d;
  end

  assign log_o = log_q;

endmodule

`default_nettype wire

// ===== rtl/core/sus_div_pipe.sv =====
`default_nettype none

module sus_div_pipe #(
  parameter int unsigned RW  = 8,
  parameter int unsigned QB  = 8,
  parameter int unsigned SBW = 1
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  wire logic [RW-1:0]  rem_i,
  input  wire logic [RW-1:0]  div_i,
  input  wire logic [SBW-1:0] sb_i,
  output logic                valid_o,
  output logic      [QB-1:0]  quo_o,
  output logic      [SBW-1:0] sb_o
);

  logic           valid_q [QB];
  logic [RW-1:0]  rem_q   [QB];
  logic [RW-1:0]  div_q   [QB];
  logic [QB-1:0]  quo_q   [QB];
  logic [SBW-1:0] sb_q    [QB];

  // One quotient bit per stage: shift the remainder, compare, subtract.
  for (genvar k = 0; k < QB; k++) begin : g_stg
    logic          v_in;
    logic [RW-1:0] rem_in;
    logic [RW-1:0] div_in;
    logic [QB-1:0] quo_in;
    logic [SBW-1:0] sb_in;
    logic [RW:0]   sh;
    logic          ge;

    if (k == 0) begin : g_first
      assign v_in   = valid_i;
      assign rem_in = rem_i;
      assign div_in = div_i;
      assign quo_in = '0;
      assign sb_in  = sb_i;
    end else begin : g_next
      assign v_in   = valid_q[k-1];
      assign rem_in = rem_q[k-1];
      assign div_in = div_q[k-1];
      assign quo_in = quo_q[k-1];
      assign sb_in  = sb_q[k-1];
    end

    assign sh = {rem_in, 1'b0};
    assign ge = sh >= {1'b0, div_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? RW'(sh - {1'b0, div_in}) : RW'(sh);
        div_q[k] <= div_in;
        quo_q[k] <= QB'({quo_in, ge});
        sb_q[k]  <= sb_in;
      end
    end
  end

  assign valid_o = valid_q[QB-1];
  assign quo_o   = quo_q[QB-1];
  assign sb_o    = sb_q[QB-1];

endmodule

`default_nettype wire

// ===== rtl/core/symmetric_uncertainty_score.sv =====
`default_nettype none

// Symmetric uncertainty of two terms, 2(Hi+Hj-Hij)/(Hi+Hj), from count triples.
//
// Input channel: in_valid_i / in_stall_o carry one word of three counts
// (first term, second term, joint). Output channel: out_valid_o / out_stall_i
// carry one word per input word: the score in unsigned fixed point with
// FRAC_BITS fraction bits and a flag for inconsistent counts (score then 0).
// The user must write total count N via cfg_we_i/cfg_wdata_i while idle; unchecked.
//
// Throughput is one word per cycle while the output is not stalled. A word
// passes the input, cell, log2 and kill stages, a 24-stage probability
// divider, the multiply, sum and set-up stages, and a FRAC_BITS + 1 stage
// score divider ahead of the output register.
//
// Reset empties the pipeline and sets N to 1. While the output register holds
// a word that the receiver stalls, the whole pipeline holds and in_stall_o is
// raised, so nothing is dropped or repeated.
module symmetric_uncertainty_score import sus_pkg::*; #(
  parameter int unsigned COUNT_WIDTH    = 32,
  parameter int unsigned FRAC_BITS      = 16,
  parameter int unsigned LOG_TABLE_BITS = 10
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] count_first_i,
  input  wire logic [31:0] count_second_i,
  input  wire logic [31:0] count_joint_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [17:0]      score_q16_o,
  output logic             counts_invalid_o
);

  localparam int unsigned CW    = COUNT_WIDTH;
  localparam int unsigned EW    = $clog2(CW);
  localparam int unsigned LOG_W = EW + LOG_FRAC;
  localparam int unsigned SW    = LOG_W + 2;
  localparam int unsigned QF    = FRAC_BITS + 1;
  localparam int unsigned NL    = NUM_CELLS + 1;

  logic adv;

  // Total count register.
  logic [31:0] total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= 32'd1;
    end else if (cfg_we_i) begin
      total_q <= cfg_wdata_i;
    end
  end

  // Advance the whole pipeline unless the output word is held by the receiver.
  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  // Stage 1: capture counts at the working width.
  logic          v1_q;
  logic [CW-1:0] ni1_q, nj1_q, nij1_q, n1_q;

  // Stage 2: consistency check and the eight cell counts.
  logic          v2_q, inv2_q;
  logic [CW-1:0] n2_q;
  logic [CW-1:0] cell2_q [NUM_CELLS];
  logic [CW-1:0] cell2_d [NUM_CELLS];
  logic [CW:0]   union1;
  logic          inv2_d;

  // Stages 3 and 4 run beside the two log2 stages.
  logic          v3_q, v4_q, inv3_q, inv4_q;
  logic [CW-1:0] n3_q, n4_q;
  logic [CW-1:0] cell3_q [NUM_CELLS];
  logic [CW-1:0] cell4_q [NUM_CELLS];
  logic [CW-1:0] log_in  [NL];
  logic [LOG_W-1:0] log4 [NL];

  // Stage 5: kill flags, log differences and divider operands.
  logic             v5_q, inv5_q;
  logic [CW-1:0]    n5_q;
  logic [CW-1:0]    rem5_q  [NUM_CELLS];
  logic [LOG_W-1:0] diff5_q [NUM_CELLS];
  logic             kill5_q [NUM_CELLS];

  // Probability divider outputs.
  logic                 pv   [NUM_CELLS];
  logic [PROB_BITS-1:0] prob [NUM_CELLS];
  logic [LOG_W+1:0]     psb  [NUM_CELLS];
  logic [NUM_CELLS-1:0] pv_vec, pinv_vec;

  // Stages 6 to 9: cell terms, sums, score division set-up.
  logic             v6_q, v7_q, v8_q, v9_q;
  logic             inv6_q, inv7_q, inv8_q, inv9_q;
  logic [LOG_W-1:0] term6_q [NUM_CELLS];
  logic [LOG_W:0]   hi7_q, hj7_q, ha7_q, hb7_q;
  logic [SW-1:0]    den8_q, hij8_q;
  logic             ok9_q, ibit9_q;
  logic [SW-1:0]    rem9_q, den9_q;
  logic             ok9_d, ibit9_d;
  logic [SW-1:0]    num9;

  // Score divider outputs.
  logic          sv;
  logic [QF-1:0] squo;
  logic [2:0]    ssb;

  // Output register.
  logic        out_valid_q, inv_out_q;
  logic [17:0] score_q;
  logic [17:0] score_d;

  // ---------------------------------------------------------------- stage 1
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ni1_q  <= CW'(count_first_i);
      nj1_q  <= CW'(count_second_i);
      nij1_q <= CW'(count_joint_i);
      n1_q   <= CW'(total_q);
    end
  end

  // ---------------------------------------------------------------- stage 2
  // Order: Ni, N-Ni, Nj, N-Nj, Nij, Ni-Nij, Nj-Nij, N-Ni-Nj+Nij.
  assign union1 = {1'b0, ni1_q} + {1'b0, nj1_q} - {1'b0, nij1_q};
  assign inv2_d = (n1_q == '0) || (nij1_q > ni1_q) || (nij1_q > nj1_q) ||
                  (ni1_q > n1_q) || (nj1_q > n1_q) || (union1 > {1'b0, n1_q});

  always_comb begin
    cell2_d[0] = ni1_q;
    cell2_d[1] = n1_q - ni1_q;
    cell2_d[2] = nj1_q;
    cell2_d[3] = n1_q - nj1_q;
    cell2_d[4] = nij1_q;
    cell2_d[5] = ni1_q - nij1_q;
    cell2_d[6] = nj1_q - nij1_q;
    cell2_d[7] = CW'({1'b0, n1_q} - union1);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      inv2_q  <= inv2_d;
      n2_q    <= n1_q;
      cell2_q <= cell2_d;
    end
  end

  // ------------------------------------------------------ stages 3 and 4
  for (genvar k = 0; k < NL; k++) begin : g_log
    if (k < NUM_CELLS) begin : g_cell
      assign log_in[k] = cell2_q[k];
    end else begin : g_total
      assign log_in[k] = n2_q;
    end

    sus_log2 #(
      .CW  (CW),
      .LTB (LOG_TABLE_BITS),
      .EW  (EW)
    ) u_log (
      .clk_i (clk_i),
      .en_i  (adv),
      .x_i   (log_in[k]),
      .log_o (log4[k])
    );
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      inv3_q  <= inv2_q;
      n3_q    <= n2_q;
      cell3_q <= cell2_q;
      inv4_q  <= inv3_q;
      n4_q    <= n3_q;
      cell4_q <= cell3_q;
    end
  end

  // ---------------------------------------------------------------- stage 5
  // Empty and full cells add nothing (0 log 0); drop them, and cells with log2 >= log2 N.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      inv5_q <= inv4_q;
      n5_q   <= n4_q;
      for (int unsigned k = 0; k < NUM_CELLS; k++) begin
        kill5_q[k] <= (cell4_q[k] == '0) || (cell4_q[k] >= n4_q) ||
                      (log4[k] >= log4[NUM_CELLS]);
        diff5_q[k] <= log4[NUM_CELLS] - log4[k];
        rem5_q[k]  <= ((cell4_q[k] == '0) || (cell4_q[k] >= n4_q)) ? '0 : cell4_q[k];
      end
    end
  end

  // ------------------------------------------- probability c/N, 24 stages
  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_prob
    sus_div_pipe #(
      .RW  (CW),
      .QB  (PROB_BITS),
      .SBW (LOG_W + 2)
    ) u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (v5_q),
      .rem_i   (rem5_q[k]),
      .div_i   (n5_q),
      .sb_i    ({inv5_q, kill5_q[k], diff5_q[k]}),
      .valid_o (pv[k]),
      .quo_o   (prob[k]),
      .sb_o    (psb[k])
    );

    assign pv_vec[k]   = pv[k];
    assign pinv_vec[k] = psb[k][LOG_W+1];
  end

  // ---------------------------------------------------------------- stage 6
  always_ff @(posedge clk_i) begin
    if (adv) begin
      inv6_q <= |pinv_vec;
      for (int unsigned k = 0; k < NUM_CELLS; k++) begin
        term6_q[k] <= psb[k][LOG_W] ? '0 :
                      LOG_W'(({{LOG_W{1'b0}}, prob[k]} * {{PROB_BITS{1'b0}},
                              psb[k][LOG_W-1:0]}) >> PROB_BITS);
      end
    end
  end

  // ---------------------------------------------------------- stages 7, 8
  always_ff @(posedge clk_i) begin
    if (adv) begin
      inv7_q <= inv6_q;
      hi7_q  <= {1'b0, term6_q[0]} + {1'b0, term6_q[1]};
      hj7_q  <= {1'b0, term6_q[2]} + {1'b0, term6_q[3]};
      ha7_q  <= {1'b0, term6_q[4]} + {1'b0, term6_q[5]};
      hb7_q  <= {1'b0, term6_q[6]} + {1'b0, term6_q[7]};
      inv8_q <= inv7_q;
      den8_q <= {1'b0, hi7_q} + {1'b0, hj7_q};
      hij8_q <= {1'b0, ha7_q} + {1'b0, hb7_q};
    end
  end

  // ---------------------------------------------------------------- stage 9
  // Take the top integer bit here; the divider then yields the units and fraction bits.
  assign num9    = den8_q - hij8_q;
  assign ok9_d   = (den8_q != '0) && (den8_q > hij8_q);
  assign ibit9_d = ok9_d && (hij8_q == '0);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      inv9_q  <= inv8_q;
      ok9_q   <= ok9_d;
      ibit9_q <= ibit9_d;
      rem9_q  <= (ok9_d && !ibit9_d) ? num9 : '0;
      den9_q  <= den8_q;
    end
  end

  // ---------------------------------------- score fraction, FRAC_BITS+1 stages
  sus_div_pipe #(
    .RW  (SW),
    .QB  (QF),
    .SBW (3)
  ) u_score_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v9_q),
    .rem_i   (rem9_q),
    .div_i   (den9_q),
    .sb_i    ({inv9_q, ok9_q, ibit9_q}),
    .valid_o (sv),
    .quo_o   (squo),
    .sb_o    (ssb)
  );

  // Valid bits of the stages outside the dividers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      v6_q        <= 1'b0;
      v7_q        <= 1'b0;
      v8_q        <= 1'b0;
      v9_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      v5_q        <= v4_q;
      v6_q        <= &pv_vec;
      v7_q        <= v6_q;
      v8_q        <= v7_q;
      v9_q        <= v8_q;
      out_valid_q <= sv;
    end
  end

  // ------------------------------------------------------- output register
  // Inconsistent counts and a zero denominator both read as score zero.
  assign score_d = (!ssb[2] && ssb[1]) ? 18'({ssb[0], squo}) : '0;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      score_q   <= score_d;
      inv_out_q <= ssb[2];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign score_q16_o      = score_q;
  assign counts_invalid_o = inv_out_q;

`ifndef SYNTHESIS
  a_inv_zero_score: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && counts_invalid_o |-> score_q16_o == '0)
    else $error("inconsistent counts with nonzero score");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(sv) && $stable(v9_q) && $stable(v1_q))
    else $error("pipeline moved while output stalled");

  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o && !v1_q && !sv)
    else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire
